// ===== hdl/kmp_pkg.sv =====
package kmp_pkg;

   // Default for the longest pattern that the failure table holds.
   localparam int MAX_PATTERN_DEFAULT = 16;

   // Widths fixed by the register map.
   localparam int PATTERN_WORD_W = 64;
   localparam int PATTERN_LEN_W  = 5;
   localparam int CSR_INDEX_W    = 2;
   localparam int CHAR_W         = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_RESULT  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_SCAN
   } kmp_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // latch the offered input transaction
      logic scan_step;    // one fallback or the final update for the held byte
      logic build_step;   // one step of the failure table construction
   } kmp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cfg_write;    // any configuration write in this cycle
      logic pattern_wr;   // a write to one of the pattern registers
      logic build_done;   // failure table complete
      logic scan_final;   // the held byte needs no further fallback
      logic item_emits;   // the held item ends a string
      logic slot_free;    // the result register can take a new result
   } kmp_status_type;

   // Byte idx of the 16-byte pattern, byte 0 in the low bits of lo.
   function automatic logic [CHAR_W-1:0] pat_byte(input logic [PATTERN_WORD_W-1:0] lo,
                                                  input logic [PATTERN_WORD_W-1:0] hi,
                                                  input logic [3:0] idx);
      logic [PATTERN_WORD_W-1:0] w;
      w = idx[3] ? hi : lo;
      return w[{idx[2:0], 3'b000} +: CHAR_W];
   endfunction

endpackage

// ===== hdl/kmp_ctrl.sv =====
module kmp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  kmp_pkg::kmp_status_type status,
   output kmp_pkg::kmp_cmd_type    cmd
);
   import kmp_pkg::*;

   kmp_state_type state_ff;
   kmp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // A configuration write takes precedence over a new byte.
            req_tready = !status.cfg_write;
            if (status.pattern_wr) begin
               state_in = ST_BUILD;
            end else if (req_tvalid && !status.cfg_write) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_BUILD: begin
            if (status.pattern_wr) begin
               state_in = ST_BUILD;
            end else if (status.build_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.build_step = 1'b1;
            end
         end
         ST_SCAN: begin
            if (status.pattern_wr) begin
               state_in = ST_BUILD;
            end else if (!status.scan_final) begin
               cmd.scan_step = 1'b1;
            end else if (!status.item_emits || status.slot_free) begin
               cmd.scan_step = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/kmp_dp.sv =====
module kmp_dp #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [kmp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [kmp_pkg::PATTERN_WORD_W-1:0]   csr_write_data,
   input  logic [kmp_pkg::CHAR_W-1:0]           req_char,
   input  logic                                 req_last,
   input  logic                                 req_empty,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic                                 rsp_match,
   input  kmp_pkg::kmp_cmd_type                 cmd,
   output kmp_pkg::kmp_status_type              status
);
   import kmp_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int SH_W  = 2 * PATTERN_WORD_W;

   // Configuration registers.
   logic [PATTERN_WORD_W-1:0] pat_lo_ff, pat_lo_in;
   logic [PATTERN_WORD_W-1:0] pat_hi_ff, pat_hi_in;
   logic [PATTERN_LEN_W-1:0]  pat_len_ff, pat_len_in;
   logic                      invert_ff, invert_in;

   // Failure table.
   logic [LEN_W-1:0] fail_tab_ff [MAX_PATTERN];
   logic [LEN_W-1:0] fail_tab_in [MAX_PATTERN];

   // Table construction: position, prefix length and the pattern shifted to position.
   logic [LEN_W-1:0] bi_ff, bi_in;
   logic [LEN_W-1:0] bk_ff, bk_in;
   logic [SH_W-1:0]  pat_sh_ff, pat_sh_in;

   // Search state and the held input transaction.
   logic [LEN_W-1:0]  k_ff, k_in;
   logic              found_ff, found_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic              empty_ff, empty_in;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_match_ff, rsp_match_in;

   logic [LEN_W-1:0]  n_sat;
   logic              pattern_wr;
   logic [LEN_W-1:0]  rd_k;
   logic [LEN_W-1:0]  tab_rd;
   logic [CHAR_W-1:0] pk;
   logic [CHAR_W-1:0] pbk;
   logic              eq_s;
   logic              eq_b;
   logic              skip;
   logic              fallback;
   logic              emits;
   logic [LEN_W-1:0]  knew;
   logic              hit;
   logic              found_next;
   logic              slot_free;
   logic [LEN_W-1:0]  bk_new;

   assign pattern_wr = csr_write_enable && ((csr_index == CSR_PATTERN_LOW) ||
                       (csr_index == CSR_PATTERN_HIGH) || (csr_index == CSR_PATTERN_LENGTH));

   assign n_sat = (pat_len_ff > PATTERN_LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                             : LEN_W'(pat_len_ff);

   // The one read port of the failure table serves either the build or the scan.
   assign rd_k   = cmd.build_step ? bk_ff : k_ff;
   assign tab_rd = fail_tab_ff[IDX_W'(rd_k - LEN_W'(1))];

   assign pk   = pat_byte(pat_lo_ff, pat_hi_ff, 4'(k_ff));
   assign pbk  = pat_byte(pat_lo_ff, pat_hi_ff, 4'(bk_ff));
   assign eq_s = (char_ff == pk);
   assign eq_b = (pat_sh_ff[CHAR_W-1:0] == pbk);

   assign skip       = empty_ff || found_ff || (n_sat == '0);
   assign fallback   = !skip && (k_ff != '0) && !eq_s;
   assign emits      = empty_ff || last_ff;
   assign knew       = k_ff + LEN_W'(eq_s);
   assign hit        = (knew >= n_sat);
   assign found_next = !empty_ff && (found_ff || (n_sat == '0) || hit);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign bk_new     = bk_ff + LEN_W'(eq_b);

   assign status.cfg_write  = csr_write_enable;
   assign status.pattern_wr = pattern_wr;
   assign status.build_done = (bi_ff >= n_sat);
   assign status.scan_final = !fallback;
   assign status.item_emits = emits;
   assign status.slot_free  = slot_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_match  = rsp_match_ff;

   always_comb begin
      pat_lo_in    = pat_lo_ff;
      pat_hi_in    = pat_hi_ff;
      pat_len_in   = pat_len_ff;
      invert_in    = invert_ff;
      fail_tab_in  = fail_tab_ff;
      bi_in        = bi_ff;
      bk_in        = bk_ff;
      pat_sh_in    = pat_sh_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_match_in = rsp_match_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pat_lo_in  = csr_write_data;
            CSR_PATTERN_HIGH:   pat_hi_in  = csr_write_data;
            CSR_PATTERN_LENGTH: pat_len_in = csr_write_data[PATTERN_LEN_W-1:0];
            CSR_INVERT_RESULT:  invert_in  = csr_write_data[0];
            default:            ;
         endcase
      end

      if (cmd.load) begin
         char_in  = req_char;
         last_in  = req_last;
         empty_in = req_empty;
         if (k_ff >= n_sat) begin
            k_in = '0;
         end
      end

      if (cmd.scan_step) begin
         if (fallback) begin
            k_in = tab_rd;
         end else if (emits) begin
            rsp_valid_in = 1'b1;
            rsp_match_in = found_next ^ invert_ff;
            k_in         = '0;
            found_in     = 1'b0;
         end else begin
            found_in = found_next;
            if (!skip) begin
               k_in = hit ? '0 : knew;
            end
         end
      end

      if (cmd.build_step) begin
         if ((bk_ff != '0) && !eq_b) begin
            bk_in = tab_rd;
         end else begin
            fail_tab_in[IDX_W'(bi_ff)] = bk_new;
            bk_in     = bk_new;
            bi_in     = bi_ff + LEN_W'(1);
            pat_sh_in = pat_sh_ff >> CHAR_W;
         end
      end

      // A pattern write restarts the table build and the string in progress.
      if (pattern_wr) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            fail_tab_in[i] = '0;
         end
         bi_in     = LEN_W'(1);
         bk_in     = '0;
         pat_sh_in = {pat_hi_in, pat_lo_in} >> CHAR_W;
         k_in      = '0;
         found_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff    <= '0;
         pat_hi_ff    <= '0;
         pat_len_ff   <= '0;
         invert_ff    <= 1'b0;
         for (int i = 0; i < MAX_PATTERN; i++) begin
            fail_tab_ff[i] <= '0;
         end
         bi_ff        <= LEN_W'(1);
         bk_ff        <= '0;
         k_ff         <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_lo_ff    <= pat_lo_in;
         pat_hi_ff    <= pat_hi_in;
         pat_len_ff   <= pat_len_in;
         invert_ff    <= invert_in;
         fail_tab_ff  <= fail_tab_in;
         bi_ff        <= bi_in;
         bk_ff        <= bk_in;
         k_ff         <= k_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_sh_ff    <= pat_sh_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      empty_ff     <= empty_in;
      rsp_match_ff <= rsp_match_in;
   end

endmodule

// ===== hdl/kmp_substring_matcher_unit.sv =====
// Substring search over a stream of string bytes by the Knuth-Morris-Pratt method.
// Each request transaction carries one byte in req_tdata, req_tlast marking the
// last byte of a string, and req_tuser marking a transaction that stands for a
// whole empty string. At the end of every string one response transaction
// carries the match flag: whether the configured pattern (up to 16 bytes, held
// in pattern_low, pattern_high and pattern_length) occurs as a contiguous
// substring, exclusive-ORed with invert_result. An empty pattern matches every
// nonempty string and an empty string never matches. A byte is first accepted;
// then the match state takes one step for each fallback through the failure
// table and one final update, which waits while a string end finds the result
// register occupied and not taken. Fallbacks never outnumber the bytes consumed.
// Any write to a pattern register rebuilds the failure table, one step a cycle,
// while no request is accepted, and restarts the string in progress. A finished
// result waits in an output register, so the next byte is accepted while it is
// still untaken.
module kmp_substring_matcher_unit #(
   parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write port.
   input  logic                               csr_write_enable,
   input  logic [kmp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kmp_pkg::PATTERN_WORD_W-1:0] csr_write_data,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] char_byte
   input  logic                               req_tlast,   // last_char
   input  logic                               req_tuser,   // empty_string
   // Response stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata    // [0] match_flag, [7:1] zero
);
   import kmp_pkg::*;

   kmp_cmd_type    cmd;
   kmp_status_type status;
   logic           rsp_match;

   // The controller sequences accepting, scanning and table building.
   kmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the registers, the failure table and the result register.
   kmp_dp #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_char         (req_tdata[CHAR_W-1:0]),
      .req_last         (req_tlast),
      .req_empty        (req_tuser),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_match        (rsp_match),
      .cmd              (cmd),
      .status           (status)
   );

   assign rsp_tdata = {7'b0000000, rsp_match};

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the substring matcher. Strings are fed in as byte
// transactions and one match flag per string is checked against a behavioural
// search model that runs inside the bench.
module tb_top;
   import kmp_pkg::*;

   // One request transaction: a byte, its end-of-string mark and the empty-string mark.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              empty;
   } text_item_type;

   // Cycles allowed after the last expected flag before the block counts as idle.
   // It covers a full run of fallbacks on a held byte and a failure table rebuild.
   localparam int SETTLE_CYCLES = 40;
   // Length of the deliberate hold-off on the response side.
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 1150;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [PATTERN_WORD_W-1:0] csr_write_data = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;   // [7:0] char_byte
   logic                      req_tlast = 1'b0; // last_char
   logic                      req_tuser = 1'b0; // empty_string
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;        // [0] match_flag, [7:1] zero

   kmp_substring_matcher_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

   // Transactions waiting to be offered, and match flags still owed by the block.
   text_item_type text_q[$];
   logic          match_flags_due[$];
   int            mismatches = 0;

   // When set, neither side inserts random idle cycles.
   bit         calm = 1'b0;
   // The main sequence bumps hold_ask; the receiver notices the change and stalls.
   int         hold_ask = 0;
   int         hold_seen = 0;
   int         hold_left = 0;

   // Configuration as the bench believes the block holds it.
   logic [PATTERN_WORD_W-1:0] pat_lo = '0;
   logic [PATTERN_WORD_W-1:0] pat_hi = '0;
   logic [PATTERN_LEN_W-1:0]  pat_len = '0;
   logic                      invert_bit = 1'b0;

   // Search state: prefix function of the pattern, current partial match length
   // and whether the pattern has already turned up in the string in progress.
   logic [PATTERN_LEN_W-1:0]  prefix_tab[MAX_PATTERN_DEFAULT];
   logic [PATTERN_LEN_W-1:0]  run_len = '0;
   logic                      seen = 1'b0;

   // Small alphabet that the current pattern is drawn from; text leans on it so
   // that partial matches and fallbacks happen often.
   logic [7:0]                alpha[3];

   text_item_type             next_item;
   logic                      due;
   int                        random_items = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Patterns longer than the table saturate to the table size.
   function automatic int active_len();
      return (pat_len > MAX_PATTERN_DEFAULT) ? MAX_PATTERN_DEFAULT : int'(pat_len);
   endfunction

   function automatic logic [7:0] pattern_char(input int idx);
      logic [2*PATTERN_WORD_W-1:0] both;
      both = {pat_hi, pat_lo};
      return both[(idx & 15) * 8 +: 8];
   endfunction

   task automatic rebuild_prefix_tab();
      int i;
      int k;
      int n;
      n = active_len();
      for (i = 0; i < MAX_PATTERN_DEFAULT; i++) prefix_tab[i] = '0;
      for (i = 1; i < n; i++) begin
         k = int'(prefix_tab[i - 1]);
         while (k > 0 && pattern_char(i) != pattern_char(k)) k = int'(prefix_tab[k - 1]);
         if (pattern_char(i) == pattern_char(k)) k++;
         prefix_tab[i] = k[PATTERN_LEN_W-1:0];
      end
   endtask

   // Mirror of a register write. Every index of the two-bit field is a real
   // register, so there is no unused index to try. Pattern writes restart the
   // string in progress; the invert bit only affects later string ends.
   task automatic apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [PATTERN_WORD_W-1:0] val);
      case (idx)
         CSR_PATTERN_LOW:    pat_lo = val;
         CSR_PATTERN_HIGH:   pat_hi = val;
         CSR_PATTERN_LENGTH: pat_len = val[PATTERN_LEN_W-1:0];
         CSR_INVERT_RESULT:  invert_bit = val[0];
         default: ;
      endcase
      if (idx != CSR_INVERT_RESULT) begin
         rebuild_prefix_tab();
         run_len = '0;
         seen = 1'b0;
      end
   endtask

   // Advances the search by one accepted transaction and records the flag owed.
   task automatic advance_search(input text_item_type it);
      int n;
      int k;
      n = active_len();
      if (it.empty) begin
         // An empty string never matches and throws away any unfinished string.
         run_len = '0;
         seen = 1'b0;
         match_flags_due.push_back(invert_bit);
      end else begin
         // Once the pattern has been found the remaining bytes change nothing.
         if (!seen) begin
            if (n == 0) begin
               seen = 1'b1;
            end else begin
               k = int'(run_len);
               if (k >= n) k = 0;
               while (k > 0 && it.ch != pattern_char(k)) k = int'(prefix_tab[k - 1]);
               if (it.ch == pattern_char(k)) k++;
               if (k >= n) begin
                  seen = 1'b1;
                  k = 0;
               end
               run_len = k[PATTERN_LEN_W-1:0];
            end
         end
         if (it.last) begin
            match_flags_due.push_back(seen ^ invert_bit);
            run_len = '0;
            seen = 1'b0;
         end
      end
   endtask

   // Request driver. The model is advanced at the edge where a transaction is
   // accepted, and the next one is presented in the same step with a single
   // assignment to each signal.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) advance_search({req_tdata, req_tlast, req_tuser});
         if (!req_tvalid || req_tready) begin
            if (text_q.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
               next_item = text_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.ch;
               req_tlast  <= next_item.last;
               req_tuser  <= next_item.empty;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side ready. A request for a hold-off keeps tready low for a long
   // stretch, counted here, so that the block backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_ask) begin
         hold_seen  <= hold_ask;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // Response monitor: every accepted transaction is matched against the oldest
   // flag still owed. The padding bits above the flag must read as zero.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (match_flags_due.size() == 0) begin
            $display("%0t: unexpected response transaction, expected none, got 8'h%02h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            due = match_flags_due.pop_front();
            if (rsp_tdata !== {7'd0, due}) begin
               $display("%0t: match flag mismatch, expected 8'h%02h, got 8'h%02h",
                        $time, {7'd0, due}, rsp_tdata);
               mismatches++;
            end
         end
      end
   end

   // One register write, held for a single edge; the model follows at that edge.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [PATTERN_WORD_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      apply_csr(idx, val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_item(input logic [7:0] ch, input logic last, input logic empty);
      text_q.push_back('{ch: ch, last: last, empty: empty});
   endtask

   // Waits until every queued transaction has gone in and every owed flag has
   // come out, then leaves time for any trailing fallbacks or a table rebuild.
   task automatic drain_and_settle();
      @(negedge clock);
      while (text_q.size() != 0 || req_tvalid || match_flags_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // A string of len bytes. Half of the strings long enough carry a full copy
   // of the pattern somewhere; the rest of the text mixes the pattern alphabet
   // with arbitrary bytes. With finish clear the string is left open.
   task automatic push_string(input int len, input bit finish);
      int n;
      int at;
      int i;
      logic [7:0] b;
      n = active_len();
      if (len == 0) begin
         // Byte and end mark of an empty-string transaction are don't-cares.
         push_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
         random_items++;
      end else begin
         at = (n > 0 && len >= n && $urandom_range(1) == 1) ? $urandom_range(len - n) : -1;
         for (i = 0; i < len; i++) begin
            if (at >= 0 && i >= at && i < at + n) begin
               b = pattern_char(i - at);
            end else if ($urandom_range(3) == 0) begin
               b = 8'($urandom);
            end else begin
               b = alpha[$urandom_range(2)];
            end
            push_item(b, finish && (i == len - 1), 1'b0);
            random_items++;
         end
      end
   endtask

   // Picks a new configuration. Patterns are built from a skewed three-letter
   // alphabet so that the prefix function has long chains; lengths include
   // zero, the full table and values beyond it. Sometimes only the invert bit
   // moves, so that a string left open carries on across the write.
   task automatic new_setup();
      logic [PATTERN_WORD_W-1:0] lo;
      logic [PATTERN_WORD_W-1:0] hi;
      logic [PATTERN_WORD_W-1:0] len_word;
      int i;
      int pick;
      int len;
      if ($urandom_range(4) != 0) begin
         for (i = 0; i < 3; i++) begin
            case ($urandom_range(5))
               0:       alpha[i] = 8'h00;
               1:       alpha[i] = 8'hFF;
               default: alpha[i] = 8'($urandom);
            endcase
         end
         for (i = 0; i < 16; i++) begin
            pick = $urandom_range(5);
            pick = (pick < 3) ? 0 : (pick < 5) ? 1 : 2;
            if (i < 8) lo[i*8 +: 8] = alpha[pick];
            else       hi[(i-8)*8 +: 8] = alpha[pick];
         end
         case ($urandom_range(9))
            0:       len = 0;
            1:       len = MAX_PATTERN_DEFAULT;
            2:       len = $urandom_range(31, MAX_PATTERN_DEFAULT + 1);
            default: len = $urandom_range(MAX_PATTERN_DEFAULT - 1, 1);
         endcase
         len_word = $urandom_range(1) ? {$urandom, $urandom} : '0;
         len_word[PATTERN_LEN_W-1:0] = len[PATTERN_LEN_W-1:0];
         if ($urandom_range(1)) begin
            write_csr(CSR_PATTERN_LOW, lo);
            write_csr(CSR_PATTERN_HIGH, hi);
            write_csr(CSR_PATTERN_LENGTH, len_word);
         end else begin
            write_csr(CSR_PATTERN_LENGTH, len_word);
            write_csr(CSR_PATTERN_HIGH, hi);
            write_csr(CSR_PATTERN_LOW, lo);
         end
         if ($urandom_range(1)) write_csr(CSR_INVERT_RESULT, {$urandom, $urandom});
      end else begin
         write_csr(CSR_INVERT_RESULT, {$urandom, $urandom});
      end
      @(negedge clock);
   endtask

   // Main sequence: reset, a directed pass over the special cases, then random
   // phases separated by configuration changes while the block is idle.
   initial begin
      int phase;
      int goal;
      int phase_start;
      int roll;
      rebuild_prefix_tab();
      alpha[0] = 8'h61;
      alpha[1] = 8'h62;
      alpha[2] = 8'h63;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset leaves an empty pattern: any nonempty string matches, and an
      // empty string does not, whatever its byte and end mark say.
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b1);
      drain_and_settle();

      // Pattern "aab". The text "aaabc" needs a fallback and has a byte after
      // the match. An open string cut short by an empty string must not match.
      write_csr(CSR_PATTERN_LOW, {40'h0, 8'h62, 8'h61, 8'h61});
      write_csr(CSR_PATTERN_LENGTH, 64'd3);
      @(negedge clock);
      push_item(8'h61, 1'b0, 1'b0);
      push_item(8'h61, 1'b0, 1'b0);
      push_item(8'h61, 1'b0, 1'b0);
      push_item(8'h62, 1'b0, 1'b0);
      push_item(8'h63, 1'b1, 1'b0);
      push_item(8'h61, 1'b0, 1'b0);
      push_item(8'h62, 1'b0, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hFF, 1'b1, 1'b0);
      // Open string "aa" followed by a pattern write: the partial match is lost.
      push_item(8'h61, 1'b0, 1'b0);
      push_item(8'h61, 1'b0, 1'b0);
      drain_and_settle();
      write_csr(CSR_PATTERN_LENGTH, 64'd3);
      @(negedge clock);
      push_item(8'h62, 1'b1, 1'b0);
      // Open string "aa" followed by an invert write: the partial match stays.
      push_item(8'h61, 1'b0, 1'b0);
      push_item(8'h61, 1'b0, 1'b0);
      drain_and_settle();
      write_csr(CSR_INVERT_RESULT, {64{1'b1}});
      @(negedge clock);
      push_item(8'h62, 1'b1, 1'b0);
      drain_and_settle();

      // Inverted flags with an empty pattern, then a length above the table
      // size with junk in the upper bits, over all-ones low and zero high pattern words.
      write_csr(CSR_PATTERN_LENGTH, 64'd0);
      @(negedge clock);
      push_item(8'h71, 1'b1, 1'b0);
      push_item(8'h5A, 1'b0, 1'b1);
      drain_and_settle();
      write_csr(CSR_PATTERN_LOW, {64{1'b1}});
      write_csr(CSR_PATTERN_HIGH, '0);
      write_csr(CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF4);
      @(negedge clock);
      push_item(8'hFF, 1'b1, 1'b0);
      drain_and_settle();

      // Random phases. Phase 2 runs with no idle cycles on either side; phase 4
      // starts with a long response hold-off while short strings keep coming.
      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         new_setup();
         calm = (phase == 2);
         phase_start = random_items;
         goal = $urandom_range(110, 60);
         if (phase == 4) begin
            hold_ask++;
            repeat (40) push_string(1, 1'b1);
         end
         while (random_items - phase_start < goal) begin
            roll = $urandom_range(19);
            if (roll < 17) begin
               push_string(($urandom_range(7) == 0) ? $urandom_range(40, 17)
                                                    : $urandom_range(12, 1), 1'b1);
            end else if (roll < 19) begin
               // Broken string: bytes with no end, then an empty string.
               push_string($urandom_range(10, 1), 1'b0);
               push_string(0, 1'b1);
            end else begin
               push_string(0, 1'b1);
            end
         end
         // Every third phase leaves a string open across the next set-up.
         if (phase % 3 == 1) push_string($urandom_range(4, 1), 1'b0);
         drain_and_settle();
         calm = 1'b0;
         phase++;
      end

      // Close any string still open so that nothing is left in flight.
      push_item(8'h00, 1'b1, 1'b1);
      drain_and_settle();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest correct run, including the hold-off.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/kmp_pkg.sv
hdl/kmp_ctrl.sv
hdl/kmp_dp.sv
hdl/kmp_substring_matcher_unit.sv
test/tb_top.sv
